[rtl/pph_pkg.sv]
`default_nettype none

package pph_pkg;

  // operation codes carried in tuser
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_ACTUAL = 2'd1;
  localparam logic [1:0] OP_ZERO   = 2'd2;

  // segment kinds
  localparam logic [1:0] KIND_LINE  = 2'd0;
  localparam logic [1:0] KIND_UPPER = 2'd1;
  localparam logic [1:0] KIND_LOWER = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_NOCFG = 3'd1;
  localparam logic [2:0] ST_OOB   = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_GEOM  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_DESIGN = 2'd0;
  localparam logic [1:0] CFG_ACTUAL = 2'd1;
  localparam logic [1:0] CFG_XSTART = 2'd2;
  localparam logic [1:0] CFG_VALID  = 2'd3;

  // last step index of each iterative operation
  localparam logic [6:0] MUL_LAST  = 7'd33;
  localparam logic [6:0] DIV_LAST  = 7'd67;
  localparam logic [6:0] SQRT_LAST = 7'd31;

  typedef enum logic [1:0] {
    AOP_MUL,
    AOP_DIV,
    AOP_SQRT
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_rsp_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
    logic signed [31:0] e;
  } seg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_SQRT,
    ST_SUM,
    ST_SHIFT,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

[rtl/piecewise_profile_height.sv]
// piecewise_profile_height: tread profile table with height queries
// input stream (s_axis): one item per operation. tuser carries the
// operation and the segment kind; tdata the five segment words and the
// query width. an append stores one segment (line or arc half) at the
// next table slot; a query scans the stored segments in order and gives
// the shifted height of the first one that holds the width.
// output stream (m_axis): exactly one result item per input item, the
// height in tdata and the status in tuser.
// configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at
// the clock edge; the user must write only while idle, the block has no check.
// steps: an append, a refused query or an empty table go straight to the
// result. a query reads and range-checks each segment scanned in turn,
// then runs the 34-step multiply and the 68-step divide for a line, or
// the 34-step multiply and the 32-step square root for an arc, then sums
// and shifts the height.
// one item is in work at a time; the next is taken the cycle after the
// previous one reaches the output register.
// reset: table emptied, config zero, no result pending; memory kept.
// stall: a result waits in the output register while m_axis_tready is
// low; the block takes and works on the next item meanwhile.
`default_nettype none

module piecewise_profile_height #(
  parameter int MAX_SEGMENTS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // config write port
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [31:0]  cfg_data_i,
  // input items
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // seg_word_a, seg_word_b, seg_word_c, seg_word_d, seg_word_e, query_width
  input  wire logic [191:0] s_axis_tdata,
  // operation [1:0], segment_kind [3:2], zero fill
  input  wire logic [7:0]   s_axis_tuser,
  // result items
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // height
  output      logic [31:0]  m_axis_tdata,
  // status [2:0], zero fill
  output      logic [7:0]   m_axis_tuser
);

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int SW = $bits(pph_pkg::seg_t);

  pph_pkg::state_e     state_q, state_d;

  // configuration registers
  logic signed [31:0]  design_q, actual_q, xstart_q;
  logic                pvalid_q;

  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       idx_q, idx_d;

  // captured query and evaluation context
  logic signed [32:0]  w_q, w_d;
  logic                actual_mode_q, actual_mode_d;
  logic                line_q, line_d;
  logic                neg_q, neg_d;
  logic signed [31:0]  base_q, base_d;
  logic [33:0]         ux_q, ux_d;
  logic [63:0]         h_q, h_d;
  logic [31:0]         res_height_q, res_height_d;
  logic [2:0]          res_status_q, res_status_d;

  // output register
  logic                m_valid_q, m_valid_d;
  logic [31:0]         m_height_q;
  logic [2:0]          m_status_q;
  logic                out_load;

  // input unpacking
  logic                accept;
  logic [1:0]          in_op, in_kind;
  logic signed [31:0]  in_query;
  logic                in_kind_ok;
  logic                can_store;

  // memory
  logic                ram_we, ram_re;
  logic [SW-1:0]       ram_rdata;
  pph_pkg::seg_t       seg_w, seg;

  // arithmetic unit
  pph_pkg::arith_req_t arith_req;
  pph_pkg::arith_rsp_t arith_rsp;
  logic [67:0]         arith_a, arith_res;
  logic [33:0]         arith_b;

  // segment evaluation
  logic signed [32:0]  a33, b33, c33, d33, e33;
  logic signed [33:0]  p;
  logic [33:0]         p_mag;
  logic signed [32:0]  dx, dy;
  logic [32:0]         ux, dy_mag;
  logic [31:0]         rm;
  logic                in_line, in_arc, seg_match, seg_geom, seg_line, last_seg;

  // height shift
  logic [63:0]         q64, off64, hs;

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign in_op      = s_axis_tuser[1:0];
  assign in_kind    = s_axis_tuser[3:2];
  assign in_query   = s_axis_tdata[191:160];
  assign in_kind_ok = (in_kind == pph_pkg::KIND_LINE) || (in_kind == pph_pkg::KIND_UPPER)
                   || (in_kind == pph_pkg::KIND_LOWER);
  assign can_store  = (count_q != CW'(MAX_SEGMENTS)) && in_kind_ok;

  assign seg_w.kind = in_kind;
  assign seg_w.a    = s_axis_tdata[31:0];
  assign seg_w.b    = s_axis_tdata[63:32];
  assign seg_w.c    = s_axis_tdata[95:64];
  assign seg_w.d    = s_axis_tdata[127:96];
  assign seg_w.e    = s_axis_tdata[159:128];
  assign seg        = pph_pkg::seg_t'(ram_rdata);

  pph_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (seg_w),
    .re_i    (ram_re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  pph_arith u_arith (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (arith_req),
    .a_i      (arith_a),
    .b_i      (arith_b),
    .rsp_o    (arith_rsp),
    .result_o (arith_res)
  );

  // range check and operands of the segment just read
  always_comb begin
    a33      = {seg.a[31], seg.a};
    b33      = {seg.b[31], seg.b};
    c33      = {seg.c[31], seg.c};
    d33      = {seg.d[31], seg.d};
    e33      = {seg.e[31], seg.e};
    p        = {w_q[32], w_q} - {a33[32], a33};
    p_mag    = p[33] ? (34'd0 - p) : p;
    dx       = c33 - a33;
    dy       = d33 - b33;
    ux       = dx[32] ? (33'd0 - dx) : dx;
    dy_mag   = dy[32] ? (33'd0 - dy) : dy;
    rm       = seg.c[31] ? (32'd0 - seg.c) : seg.c;
    in_line  = (a33 <= c33) ? ((w_q >= a33) && (w_q <= c33))
                            : ((w_q >= c33) && (w_q <= a33));
    in_arc   = (w_q >= d33) && (w_q <= e33);
    seg_line = (seg.kind == pph_pkg::KIND_LINE);
    // vertical line, or width outside the circle
    if (seg_line) begin
      seg_match = in_line;
      seg_geom  = (dx == 33'sd0);
    end else begin
      seg_match = in_arc;
      seg_geom  = p_mag > {2'b00, rm};
    end
    last_seg = ((idx_q + CW'(1)) == count_q);
  end

  // shift to the reference height, in 64-bit wrapping arithmetic
  always_comb begin
    q64 = arith_res[63:0];
    if (actual_mode_q) begin
      off64 = {{32{actual_q[31]}}, actual_q} - {{32{design_q[31]}}, design_q};
    end else begin
      off64 = 64'd0 - {{32{design_q[31]}}, design_q};
    end
    hs = h_q + off64;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pph_pkg::ST_IDLE: begin
        if (accept) begin
          if (((in_op == pph_pkg::OP_ACTUAL) || (in_op == pph_pkg::OP_ZERO))
              && pvalid_q && (count_q != '0)) begin
            state_d = pph_pkg::ST_READ;
          end else begin
            state_d = pph_pkg::ST_DONE;
          end
        end
      end
      pph_pkg::ST_READ:  state_d = pph_pkg::ST_EVAL;
      pph_pkg::ST_EVAL: begin
        if (seg_match) begin
          state_d = seg_geom ? pph_pkg::ST_DONE : pph_pkg::ST_MUL;
        end else begin
          state_d = last_seg ? pph_pkg::ST_DONE : pph_pkg::ST_READ;
        end
      end
      pph_pkg::ST_MUL: begin
        if (arith_rsp.done) begin
          state_d = line_q ? pph_pkg::ST_DIV : pph_pkg::ST_SQRT;
        end
      end
      pph_pkg::ST_DIV, pph_pkg::ST_SQRT: begin
        if (arith_rsp.done) begin
          state_d = pph_pkg::ST_SUM;
        end
      end
      pph_pkg::ST_SUM:   state_d = pph_pkg::ST_SHIFT;
      pph_pkg::ST_SHIFT: state_d = pph_pkg::ST_DONE;
      pph_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = pph_pkg::ST_IDLE;
        end
      end
      default: state_d = pph_pkg::ST_IDLE;
    endcase
  end

  // control outputs: handshake, memory and arithmetic requests
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    arith_req     = '{start: 1'b0, op: pph_pkg::AOP_MUL};
    arith_a       = '0;
    arith_b       = '0;
    out_load      = 1'b0;
    case (state_q)
      pph_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        ram_we        = accept && (in_op == pph_pkg::OP_APPEND) && can_store;
      end
      pph_pkg::ST_READ: ram_re = 1'b1;
      pph_pkg::ST_EVAL: begin
        arith_req.start = seg_match && !seg_geom;
        arith_req.op    = pph_pkg::AOP_MUL;
        if (seg_line) begin
          arith_a = {34'd0, p_mag};
          arith_b = {1'b0, dy_mag};
        end else begin
          // r*r - u*u as (r - u) * (r + u)
          arith_a = {34'd0, {2'b00, rm} - p_mag};
          arith_b = {2'b00, rm} + p_mag;
        end
      end
      pph_pkg::ST_MUL: begin
        arith_req.start = arith_rsp.done;
        if (line_q) begin
          // rounded division: add half the divisor first
          arith_req.op = pph_pkg::AOP_DIV;
          arith_a      = {4'd0, arith_res[63:0] + {31'd0, ux_q[33:1]}};
          arith_b      = ux_q;
        end else begin
          arith_req.op = pph_pkg::AOP_SQRT;
          arith_a      = arith_res;
          arith_b      = '0;
        end
      end
      pph_pkg::ST_DONE: out_load = !m_valid_q || m_axis_tready;
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    count_d       = count_q;
    idx_d         = idx_q;
    w_d           = w_q;
    actual_mode_d = actual_mode_q;
    line_d        = line_q;
    neg_d         = neg_q;
    base_d        = base_q;
    ux_d          = ux_q;
    h_d           = h_q;
    res_height_d  = res_height_q;
    res_status_d  = res_status_q;
    case (state_q)
      pph_pkg::ST_IDLE: begin
        if (accept) begin
          idx_d         = '0;
          w_d           = {in_query[31], in_query} + {xstart_q[31], xstart_q};
          actual_mode_d = (in_op == pph_pkg::OP_ACTUAL);
          res_height_d  = '0;
          res_status_d  = pph_pkg::ST_OK;
          case (in_op)
            pph_pkg::OP_APPEND: begin
              if (count_q == CW'(MAX_SEGMENTS)) begin
                res_status_d = pph_pkg::ST_FULL;
              end else if (!in_kind_ok) begin
                res_status_d = pph_pkg::ST_GEOM;
              end else begin
                count_d = count_q + CW'(1);
              end
            end
            pph_pkg::OP_ACTUAL, pph_pkg::OP_ZERO: begin
              if (!pvalid_q) begin
                res_status_d = pph_pkg::ST_NOCFG;
              end else if (count_q == '0) begin
                res_status_d = pph_pkg::ST_OOB;
              end
            end
            default: begin
              res_status_d = pph_pkg::ST_OK;
            end
          endcase
        end
      end
      pph_pkg::ST_EVAL: begin
        line_d = seg_line;
        base_d = seg.b;
        ux_d   = {1'b0, ux};
        neg_d  = seg_line ? ((p[33] ^ dy[32]) ^ dx[32]) : (seg.kind == pph_pkg::KIND_LOWER);
        if (seg_match) begin
          if (seg_geom) begin
            res_status_d = pph_pkg::ST_GEOM;
          end
        end else if (last_seg) begin
          res_status_d = pph_pkg::ST_OOB;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      pph_pkg::ST_SUM: begin
        h_d = {{32{base_q[31]}}, base_q} + (neg_q ? (64'd0 - q64) : q64);
      end
      pph_pkg::ST_SHIFT: begin
        // saturate to the signed 32-bit range
        if (!hs[63] && (hs[62:31] != '0)) begin
          res_height_d = 32'h7fff_ffff;
        end else if (hs[63] && (hs[62:31] != '1)) begin
          res_height_d = 32'h8000_0000;
        end else begin
          res_height_d = hs[31:0];
        end
        res_status_d = pph_pkg::ST_OK;
      end
      default: begin
        h_d = h_q;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pph_pkg::ST_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
      design_q  <= '0;
      actual_q  <= '0;
      xstart_q  <= '0;
      pvalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pph_pkg::CFG_DESIGN: design_q <= cfg_data_i;
          pph_pkg::CFG_ACTUAL: actual_q <= cfg_data_i;
          pph_pkg::CFG_XSTART: xstart_q <= cfg_data_i;
          pph_pkg::CFG_VALID:  pvalid_q <= cfg_data_i[0];
          default:             pvalid_q <= pvalid_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q         <= idx_d;
    w_q           <= w_d;
    actual_mode_q <= actual_mode_d;
    line_q        <= line_d;
    neg_q         <= neg_d;
    base_q        <= base_d;
    ux_q          <= ux_d;
    h_q           <= h_d;
    res_height_q  <= res_height_d;
    res_status_q  <= res_status_d;
    if (out_load) begin
      m_height_q <= (res_status_q == pph_pkg::ST_OK) ? res_height_q : 32'd0;
      m_status_q <= res_status_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_height_q;
  assign m_axis_tuser  = {5'd0, m_status_q};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_SEGMENTS))
    else $error("segment count beyond table size");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_op == pph_pkg::OP_APPEND) && can_store)
      |=> (count_q == ($past(count_q) + CW'(1))))
    else $error("stored append did not advance count");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (m_status_q != pph_pkg::ST_OK)) |-> (m_height_q == 32'd0))
    else $error("nonzero height with error status");
`endif

endmodule

`default_nettype wire

[rtl/pph_ram.sv]
`default_nettype none

module pph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/pph_arith.sv]
`default_nettype none

module pph_arith (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire pph_pkg::arith_req_t req_i,
  input  wire logic [67:0]         a_i,
  input  wire logic [33:0]         b_i,
  output      pph_pkg::arith_rsp_t rsp_o,
  output      logic [67:0]         result_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [6:0]          cnt_q, cnt_d;
  pph_pkg::arith_op_e  op_q, op_d;
  logic [67:0]         p_q, p_d;
  logic [34:0]         r_q, r_d;
  logic [33:0]         b_q, b_d;
  logic [63:0]         res_q, res_d;
  logic [63:0]         bit_q, bit_d;

  logic [34:0]         mul_sum;
  logic [34:0]         div_t;
  logic                div_ge;
  logic [63:0]         sq_sum;
  logic                sq_ge;

  always_comb begin
    mul_sum = {1'b0, p_q[67:34]} + (p_q[0] ? {1'b0, b_q} : 35'd0);
    div_t   = {r_q[33:0], p_q[67]};
    div_ge  = div_t >= {1'b0, b_q};
    sq_sum  = res_q + bit_q;
    sq_ge   = p_q[63:0] >= sq_sum;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    p_d    = p_q;
    r_d    = r_q;
    b_d    = b_q;
    res_d  = res_q;
    bit_d  = bit_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      b_d    = b_i;
      r_d    = '0;
      res_d  = '0;
      bit_d  = 64'd1 << 62;
      case (req_i.op)
        pph_pkg::AOP_MUL: begin
          p_d   = {34'd0, a_i[33:0]};
          cnt_d = pph_pkg::MUL_LAST;
        end
        pph_pkg::AOP_DIV: begin
          p_d   = a_i;
          cnt_d = pph_pkg::DIV_LAST;
        end
        pph_pkg::AOP_SQRT: begin
          p_d   = {4'd0, a_i[63:0]};
          cnt_d = pph_pkg::SQRT_LAST;
        end
        default: begin
          p_d   = a_i;
          cnt_d = '0;
        end
      endcase
    end else if (busy_q) begin
      case (op_q)
        pph_pkg::AOP_MUL: begin
          // shift-add, one multiplier bit a step
          p_d = {mul_sum, p_q[33:1]};
        end
        pph_pkg::AOP_DIV: begin
          // restoring division, one quotient bit a step
          r_d = div_ge ? (div_t - {1'b0, b_q}) : div_t;
          p_d = {p_q[66:0], div_ge};
        end
        pph_pkg::AOP_SQRT: begin
          // digit-by-digit root, one result bit a step
          if (sq_ge) begin
            p_d   = {4'd0, p_q[63:0] - sq_sum};
            res_d = {1'b0, res_q[63:1]} + bit_q;
          end else begin
            res_d = {1'b0, res_q[63:1]};
          end
          bit_d = {2'b00, bit_q[63:2]};
        end
        default: begin
          p_d = p_q;
        end
      endcase
      if (cnt_q == 7'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    p_q   <= p_d;
    r_q   <= r_d;
    b_q   <= b_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign result_o   = (op_q == pph_pkg::AOP_SQRT) ? {4'd0, res_q} : p_q;

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("arith start while busy");
`endif

endmodule

`default_nettype wire
